// ===== hdl/sipdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SIP duplicate filter package
// Shared constants, register indexes, table entry layout and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sipdf_pkg;

   localparam int TableEntriesDef = 64;

   localparam int KeyWidth   = 224;
   localparam int StampWidth = 48;

   localparam logic [15:0] DupWindowReset   = 16'd100;
   localparam logic [19:0] CleanupReset     = 20'd10000;
   localparam logic [19:0] MaxAgeReset      = 20'd5000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DUP_WINDOW = 2'd0;
   localparam logic [1:0] CSR_CLEANUP    = 2'd1;
   localparam logic [1:0] CSR_MAX_AGE    = 2'd2;

   // One table entry.
   typedef struct packed {
      logic                  valid;
      logic [StampWidth-1:0] stamp;
      logic [KeyWidth-1:0]   key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_rst;
      logic clear;
      logic search;
      logic update;
      logic sweep;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic sweep_go;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/sipdf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SIP duplicate filter controller
// Sequences the clearing pass, the table search, the update, the optional
// age-out sweep and the response handshake.
// ----------------------------------------------------------------------------
module sipdf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output sipdf_pkg::cmd_type        cmd,
   input  wire sipdf_pkg::status_type status
);
   import sipdf_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_SWEEP  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture  = 1'b1;
               cmd.scan_rst = 1'b1;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.sweep_go) begin
               cmd.scan_rst = 1'b1;
               state_in     = ST_SWEEP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/sipdf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SIP duplicate filter datapath
// Holds the entry table memory, the scan counter, the search results, the
// configuration registers, the sweep time and the response register.
// ----------------------------------------------------------------------------
module sipdf_dp #(
   parameter int TABLE_ENTRIES = sipdf_pkg::TableEntriesDef
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sipdf_pkg::cmd_type    cmd,
   output sipdf_pkg::status_type      status,
   input  wire logic [271:0]          req_data,
   input  wire logic                  req_end_of_batch,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [19:0]           csr_data,
   output logic                       pass_on,
   output logic                       table_full,
   output logic [6:0]                 entries_in_use
);
   import sipdf_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // Table memory and its registered read port.
   entry_type table_mem_ff [TABLE_ENTRIES];
   entry_type rd_ff;

   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff;
   logic [AW-1:0] pidx_ff;
   logic          scan_end, rd_en;

   logic [KeyWidth-1:0]   key_ff;
   logic [StampWidth-1:0] now_ff;
   logic                  eob_ff;

   logic                  hit_ff, free_ff;
   logic [AW-1:0]         hit_idx_ff, free_idx_ff;
   logic [StampWidth-1:0] hit_stamp_ff;

   logic [15:0] win_ff;
   logic [19:0] int_ff, age_ff;
   logic [StampWidth-1:0] last_ff, limit_ff;
   logic [CW-1:0] count_ff;
   logic pass_ff, full_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   entry_type             wr_data;
   logic                  dup, sweep_due, age_ok, first_sweep, remove;

   assign scan_end = (idx_ff == CW'(TABLE_ENTRIES));
   assign rd_en    = (cmd.search | cmd.sweep) & ~scan_end;
   assign status.scan_done = scan_end & ~pend_ff;

   // Time comparisons, one bit wider so the sums cannot wrap.
   assign dup = ({1'b0, hit_stamp_ff} + {33'd0, win_ff}) > {1'b0, now_ff};
   assign sweep_due = ({1'b0, last_ff} + {29'd0, int_ff}) < {1'b0, now_ff};
   assign age_ok = now_ff >= {28'd0, age_ff};
   assign first_sweep = (last_ff == '0);
   assign status.sweep_go = eob_ff & ~first_sweep & sweep_due & age_ok;

   assign remove = cmd.sweep & pend_ff & rd_ff.valid & (rd_ff.stamp < limit_ff);

   // Memory write selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = '0;
      if (cmd.clear) begin
         wr_en = ~scan_end;
      end else if (cmd.update) begin
         wr_data = '{valid: 1'b1, stamp: now_ff, key: key_ff};
         if (hit_ff) begin
            wr_en   = dup;
            wr_addr = hit_idx_ff;
         end else begin
            wr_en   = free_ff;
            wr_addr = free_idx_ff;
         end
      end else if (remove) begin
         wr_en         = 1'b1;
         wr_addr       = pidx_ff;
         wr_data       = rd_ff;
         wr_data.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= table_mem_ff[idx_ff[AW-1:0]];
      end
   end

   // Scan counter.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_rst) begin
         idx_in = '0;
      end else if ((cmd.clear | cmd.search | cmd.sweep) & ~scan_end) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         last_ff  <= '0;
         win_ff   <= DupWindowReset;
         int_ff   <= CleanupReset;
         age_ff   <= MaxAgeReset;
      end else begin
         idx_ff  <= idx_in;
         pend_ff <= rd_en;
         if (cmd.update & ~hit_ff & free_ff) begin
            count_ff <= count_ff + CW'(1);
         end else if (remove) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.update & eob_ff) begin
            if (first_sweep | sweep_due) begin
               last_ff <= now_ff;
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_DUP_WINDOW: win_ff <= csr_data[15:0];
               CSR_CLEANUP:    int_ff <= csr_data;
               CSR_MAX_AGE:    age_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Request capture, search results and response.
   always_ff @(posedge clock) begin
      pidx_ff <= idx_ff[AW-1:0];
      if (cmd.capture) begin
         key_ff  <= req_data[223:0];
         now_ff  <= req_data[271:224];
         eob_ff  <= req_end_of_batch;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end
      if (cmd.search & pend_ff) begin
         if (rd_ff.valid) begin
            if (~hit_ff && (rd_ff.key == key_ff)) begin
               hit_ff       <= 1'b1;
               hit_idx_ff   <= pidx_ff;
               hit_stamp_ff <= rd_ff.stamp;
            end
         end else if (~free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= pidx_ff;
         end
      end
      if (cmd.update) begin
         pass_ff  <= ~(hit_ff & dup);
         full_ff  <= ~hit_ff & ~free_ff;
         limit_ff <= now_ff - {28'd0, age_ff};
      end
   end

   assign pass_on        = pass_ff;
   assign table_full     = full_ff;
   assign entries_in_use = 7'(count_ff);

endmodule
`default_nettype wire

// ===== hdl/sip_message_duplicate_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SIP message duplicate filter
// Drops SIP messages repeated within a window and ages out old entries.
// ----------------------------------------------------------------------------
// After reset a clearing pass runs over every entry before the first request is
// taken. Each request scans the table through the single memory read port, one
// entry per cycle, then takes an update step and a response step; when the
// end-of-batch age-out sweep runs, a second scan of the table is added. One
// request is in work at a time.
module sip_message_duplicate_filter #(
   parameter int TABLE_ENTRIES = sipdf_pkg::TableEntriesDef
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // source_address, destination_address, source_port, destination_port,
   // ack_number, seq_number, message_digest, time_ms
   input  wire logic [271:0] req_tdata,
   // end_of_batch
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // entries_in_use, zero padded to a byte
   output logic [7:0]        rsp_tdata,
   // pass_on, table_full
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [19:0]  csr_data
);
   import sipdf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       pass_on, table_full;
   logic [6:0] entries_in_use;

   assign csr_ready = 1'b1;

   sipdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sipdf_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_tdata),
      .req_end_of_batch (req_tuser),
      .csr_write        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pass_on          (pass_on),
      .table_full       (table_full),
      .entries_in_use   (entries_in_use)
   );

   assign rsp_tdata = {1'b0, entries_in_use};
   assign rsp_tuser = {table_full, pass_on};

endmodule
`default_nettype wire

// ===== hdl/sipdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SIP duplicate filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module sipdf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // A pending response stays until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped before it was taken");

   // A new request is not taken right after one was accepted.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // No request is taken while a response waits.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   // A dropped duplicate never reports a full table.
   a_drop_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("dropped message flagged as table full");

   // The padding bit of the response data is never set.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7])
      else $error("padding bit set in response");

endmodule

bind sip_message_duplicate_filter sipdf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
